@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ src/crp_pkg.sv @@
// ---------------------------------------------------------------------------
// Cursor report parser package
// Payload types, character codes, parse phases and limits.
// ---------------------------------------------------------------------------
package crp_pkg;

    localparam int CrpMaxReplyBytesDef = 15;

    localparam int unsigned NumW = 10;
    localparam logic [NumW-1:0] NumLimit = 10'd999;

    localparam logic [7:0] ChEsc      = 8'h1B;
    localparam logic [7:0] ChLBracket = 8'h5B;
    localparam logic [7:0] ChSemi     = 8'h3B;
    localparam logic [7:0] ChR        = 8'h52;
    localparam logic [7:0] ChZero     = 8'h30;
    localparam logic [7:0] ChNine     = 8'h39;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       start_of_reply;
    } t_in_item;

    typedef struct packed {
        logic            reply_valid;
        logic [NumW-1:0] row_count;
        logic [NumW-1:0] column_count;
    } t_out_item;

    // One parse step's outcome as seen by the output register.
    typedef struct packed {
        logic      present;
        t_out_item item;
    } t_step_result;

    typedef enum logic [4:0] {
        PH_ESC     = 5'b00001,
        PH_BRACKET = 5'b00010,
        PH_ROWS    = 5'b00100,
        PH_COLS    = 5'b01000,
        PH_DONE    = 5'b10000
    } t_phase;

endpackage

@@ src/crp_core.sv @@
// ---------------------------------------------------------------------------
// Cursor report parse core
// Parse state registers and the one-byte step that updates them.
// ---------------------------------------------------------------------------
module crp_core #(
    parameter int MAX_REPLY_BYTES = crp_pkg::CrpMaxReplyBytesDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  crp_pkg::t_in_item     i_item,
    output crp_pkg::t_step_result o_result
);
    import crp_pkg::*;

    localparam int CntW = $clog2(MAX_REPLY_BYTES + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_REPLY_BYTES);

    t_phase          r_phase, n_phase;
    logic [NumW-1:0] r_row, n_row;
    logic [NumW-1:0] r_col, n_col;
    logic            r_digit, n_digit;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_broken, n_broken;

    always_comb begin
        logic [7:0]      b;
        logic            is_digit;
        logic [NumW-1:0] acc;
        logic [13:0]     prod;
        t_phase          ph;

        b        = i_item.byte_value;
        is_digit = (b >= ChZero) && (b <= ChNine);

        // A start byte clears the parse and is then taken as the first byte.
        if (i_item.start_of_reply) begin
            ph       = PH_ESC;
            n_row    = '0;
            n_col    = '0;
            n_digit  = 1'b0;
            n_cnt    = '0;
            n_broken = 1'b0;
        end else begin
            ph       = r_phase;
            n_row    = r_row;
            n_col    = r_col;
            n_digit  = r_digit;
            n_cnt    = r_cnt;
            n_broken = r_broken;
        end
        n_phase  = ph;
        o_result = '0;

        acc  = (ph == PH_ROWS) ? n_row : n_col;
        prod = {4'b0, acc} * 14'd10 + {10'b0, b[3:0]};

        if (ph != PH_DONE) begin
            n_cnt = n_cnt + CntW'(1);
            if (b == ChR) begin
                o_result.present = 1'b1;
                if (!n_broken && ph == PH_COLS && n_digit && n_row != '0 && n_col != '0) begin
                    o_result.item.reply_valid  = 1'b1;
                    o_result.item.row_count    = n_row;
                    o_result.item.column_count = n_col;
                end
                n_phase = PH_DONE;
            end else begin
                if (!n_broken) begin
                    unique case (ph) inside
                        PH_ESC: begin
                            if (b == ChEsc) n_phase = PH_BRACKET;
                            else n_broken = 1'b1;
                        end
                        PH_BRACKET: begin
                            if (b == ChLBracket) n_phase = PH_ROWS;
                            else n_broken = 1'b1;
                        end
                        PH_ROWS, PH_COLS: begin
                            if (is_digit) begin
                                if (prod > {4'b0, NumLimit}) begin
                                    n_broken = 1'b1;
                                end else begin
                                    n_digit = 1'b1;
                                    if (ph == PH_ROWS) n_row = prod[NumW-1:0];
                                    else n_col = prod[NumW-1:0];
                                end
                            end else if (ph == PH_ROWS && b == ChSemi && n_digit
                                         && n_row != '0) begin
                                n_phase = PH_COLS;
                                n_digit = 1'b0;
                            end else begin
                                n_broken = 1'b1;
                            end
                        end
                        default: n_broken = n_broken;
                    endcase
                end
                // The last allowed byte ends the reply as invalid.
                if (n_cnt >= CntMax) begin
                    o_result.present = 1'b1;
                    n_phase = PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_DONE;
            r_row    <= '0;
            r_col    <= '0;
            r_digit  <= 1'b0;
            r_cnt    <= '0;
            r_broken <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_row    <= n_row;
            r_col    <= n_col;
            r_digit  <= n_digit;
            r_cnt    <= n_cnt;
            r_broken <= n_broken;
        end
    end

endmodule

@@ src/cursor_report_parser_top.sv @@
// ---------------------------------------------------------------------------
// Cursor report parser, top level
// Parses terminal cursor-position replies (ESC [ rows ; cols R) byte by byte.
// ---------------------------------------------------------------------------
// Usage: bytes enter on the input channel (i_in_valid / o_in_stall /
// i_in_data), one byte per transfer, with start_of_reply set on the first
// byte of each reply. When a reply ends, at its first R or at its
// MAX_REPLY_BYTES-th byte, one result transfer leaves on the output channel
// (o_out_valid / i_out_stall / o_out_data) carrying the valid flag and the
// row and column counts; both counts are zero when the reply is invalid.
// Bytes that arrive outside a reply produce nothing.
// A byte passes through two registers on its way to the result: the input
// register, then the parse step into the result register. One byte is taken
// every cycle while the receiver does not stall; the rate is set by the parse
// step, which updates the phase and accumulators at once.
// Reset is synchronous and active low; afterwards the parser waits for a
// start byte and both registers are empty.
// When the receiver stalls with a result pending, the parse step halts and
// the input register holds one byte, then the input channel stalls too.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cursor_report_parser_top #(
    parameter int MAX_REPLY_BYTES = crp_pkg::CrpMaxReplyBytesDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  crp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output crp_pkg::t_out_item o_out_data
);
    import crp_pkg::*;

    logic         r_in_valid;
    t_in_item     r_in;
    logic         r_out_valid;
    t_out_item    r_out;
    logic         step;
    t_step_result result;

    // The parse step runs whenever a byte is held and the result register can
    // take whatever the step produces.
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    crp_core #(
        .MAX_REPLY_BYTES(MAX_REPLY_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .o_result(result)
    );

    // The result register is free when empty or when its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= step && result.present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && result.present) begin
            r_out <= result.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A valid reply always carries counts in range.
    `ASSERT_SAME(a_valid_counts, i_clk, i_rst_n, o_out_valid && o_out_data.reply_valid,
        o_out_data.row_count != '0 && o_out_data.column_count != '0
        && o_out_data.row_count <= NumLimit && o_out_data.column_count <= NumLimit)
    // An invalid reply reports zero counts.
    `ASSERT_SAME(a_invalid_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.reply_valid,
        o_out_data.row_count == '0 && o_out_data.column_count == '0)
    // The input side stalls only while a byte waits in the input register.
    `ASSERT_SAME(a_stall_held, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid)
    // A parse step that produces a result shows it in the next cycle.
    `ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, step && result.present, o_out_valid)

endmodule
